// File: hw/rtl/ste_pkg.sv
// ste_pkg: shared constants, codes and controller/datapath command types
// for the sorted table engine; no dependencies
package ste_pkg;

    localparam int unsigned CAPACITY_DEF  = 256;
    localparam int unsigned KEY_WIDTH_DEF = 32;
    localparam int unsigned FUNC_W   = 3;
    localparam int unsigned SLOT_W   = 9;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned READ_W   = 32;
    localparam int unsigned MODE_W   = 2;

    localparam logic [FUNC_W-1:0] FN_ADD    = 3'd0;
    localparam logic [FUNC_W-1:0] FN_INSERT = 3'd1;
    localparam logic [FUNC_W-1:0] FN_DELETE = 3'd2;
    localparam logic [FUNC_W-1:0] FN_UPDATE = 3'd3;
    localparam logic [FUNC_W-1:0] FN_SEARCH = 3'd4;
    localparam logic [FUNC_W-1:0] FN_READ   = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FOUND  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BADIDX = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL   = 3'd4;

    localparam logic [MODE_W-1:0] MD_PLAIN  = 2'd0;
    localparam logic [MODE_W-1:0] MD_SORTED = 2'd1;
    localparam logic [MODE_W-1:0] MD_UNIQUE = 2'd2;

    typedef enum logic [2:0] {
        RD_NONE,
        RD_MID,     // read entry at mid for search compare
        RD_LO,      // read entry at lo for final compare
        RD_SHUP,    // read entry at cursor-1 (insert shift)
        RD_SHDN,    // read entry at cursor+1 (delete shift)
        RD_SLOT     // read entry at slot
    } rd_sel_t;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_SHUP,    // write read data to cursor, cursor--
        WR_SHDN,    // write read data to cursor, cursor++
        WR_KEY      // write key at cursor
    } wr_sel_t;

    // controller to datapath
    typedef struct packed {
        logic    load;        // capture request
        logic    srch_init;   // lo=0, hi=count-1
        rd_sel_t rd;
        logic    srch_step;   // compare read data with key at mid
        logic    srch_final;  // compare read data with key at lo
        logic    cur_from_cnt;
        logic    cur_from_slot;
        logic    cur_from_pos;
        wr_sel_t wr;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    take_rv;
    } ste_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic empty;
        logic full;
        logic slot_gt_cnt;
        logic slot_ge_cnt;
        logic srch_done;   // lo >= hi or equal key seen
        logic hit;         // equal key seen
        logic cur_gt_pos;  // insert shift left to do
        logic cur_last;    // cursor+1 >= count (delete shift done)
    } ste_sts_t;

endpackage

// File: hw/rtl/ste_ram.sv
// ste_ram: generic single-port ram, one write or one read per cycle,
// registered read data; no dependencies
module ste_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// File: hw/rtl/ste_datapath.sv
// ste_datapath: request registers, search bounds, shift cursor, fill count
// and the entry ram; depends on ste_pkg and ste_ram
module ste_datapath #(
    parameter int unsigned CAPACITY  = ste_pkg::CAPACITY_DEF,
    parameter int unsigned KEY_WIDTH = ste_pkg::KEY_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ste_pkg::ste_cmd_t           cmd,
    output ste_pkg::ste_sts_t           sts,
    input  logic [KEY_WIDTH-1:0]        key,
    input  logic [ste_pkg::SLOT_W-1:0]  slot,
    input  logic                        set_pos_lo,
    input  logic                        set_pos_mid,
    input  logic                        set_pos_lo1,
    input  logic                        set_pos_slot,
    input  logic                        set_pos_cnt,
    output logic [ste_pkg::SLOT_W-1:0]  pos,
    output logic [ste_pkg::READ_W-1:0]  read_val,
    output logic [ste_pkg::SLOT_W-1:0]  cnt
);
    import ste_pkg::*;

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);

    logic [KEY_WIDTH-1:0] key_reg;
    logic [SLOT_W-1:0]    slot_reg;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        lo_reg, hi_reg, cur_reg, pos_reg;
    logic [CW-1:0]        mid;
    logic [CW-1:0]        lo_clamp;
    logic                 hit_reg;
    logic [READ_W-1:0]    rv_reg;
    logic [CW:0]          sum;
    logic [CW-1:0]        ram_idx;
    logic                 we;
    logic [KEY_WIDTH-1:0] wdata, rdata;
    logic [CW-1:0]        slot_ext;

    assign sum      = {1'b0, lo_reg} + {1'b0, hi_reg} + {{CW{1'b0}}, 1'b1};
    assign mid      = sum[CW:1];
    assign slot_ext = CW'(slot_reg);
    // search can run lo one past the last entry
    assign lo_clamp = (lo_reg >= count_reg) ? count_reg - CW'(1) : lo_reg;

    always_comb
    begin
        ram_idx = cur_reg;
        unique case (cmd.rd)
            RD_MID:  ram_idx = mid;
            RD_LO:   ram_idx = lo_clamp;
            RD_SHUP: ram_idx = cur_reg - CW'(1);
            RD_SHDN: ram_idx = cur_reg + CW'(1);
            RD_SLOT: ram_idx = slot_ext;
            default: ram_idx = cur_reg;
        endcase
        we    = (cmd.wr != WR_NONE);
        wdata = (cmd.wr == WR_KEY) ? key_reg : rdata;
    end

    ste_ram #(.WIDTH(KEY_WIDTH), .DEPTH(CAPACITY)) u_ram (
        .clk   (clk),
        .we    (we),
        .addr  (ram_idx[AW-1:0]),
        .wdata (wdata),
        .rdata (rdata)
    );

    always_comb
    begin
        count_next = count_reg;
        if (cmd.cnt_inc)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.cnt_dec)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg  <= key;
            slot_reg <= slot;
            hit_reg  <= 1'b0;
            rv_reg   <= '0;
        end
        if (cmd.srch_init)
        begin
            lo_reg  <= '0;
            hi_reg  <= count_reg - CW'(1);
            hit_reg <= 1'b0;
        end
        if (cmd.srch_step)
        begin
            if (key_reg == rdata)
            begin
                hit_reg <= 1'b1;
                lo_reg  <= mid;
                hi_reg  <= mid;
            end
            else if (key_reg > rdata)
            begin
                hi_reg <= mid - CW'(1);
            end
            else
            begin
                lo_reg <= mid + CW'(1);
            end
        end
        if (cmd.srch_final)
        begin
            hit_reg <= (rdata == key_reg);
            lo_reg  <= (rdata > key_reg) ? lo_clamp + CW'(1) : lo_clamp;
        end
        if (set_pos_lo)        pos_reg <= lo_reg;
        else if (set_pos_mid)  pos_reg <= mid;
        else if (set_pos_lo1)  pos_reg <= lo_reg + CW'(1);
        else if (set_pos_slot) pos_reg <= slot_ext;
        else if (set_pos_cnt)  pos_reg <= count_reg;
        if (cmd.cur_from_cnt)       cur_reg <= count_reg;
        else if (cmd.cur_from_slot) cur_reg <= slot_ext;
        else if (cmd.cur_from_pos)  cur_reg <= lo_reg;
        else if (cmd.wr == WR_SHUP) cur_reg <= cur_reg - CW'(1);
        else if (cmd.wr == WR_SHDN) cur_reg <= cur_reg + CW'(1);
        if (cmd.take_rv)
        begin
            rv_reg <= READ_W'(rdata);
        end
    end

    always_comb
    begin
        sts.empty       = (count_reg == '0);
        sts.full        = (count_reg >= CW'(CAPACITY));
        sts.slot_gt_cnt = ({1'b0, slot_reg} > (SLOT_W + 1)'(count_reg));
        sts.slot_ge_cnt = ({1'b0, slot_reg} >= (SLOT_W + 1)'(count_reg));
        sts.srch_done   = (lo_reg >= hi_reg) || hit_reg;
        sts.hit         = hit_reg;
        sts.cur_gt_pos  = (cur_reg > pos_reg);
        sts.cur_last    = ((CW + 1)'(cur_reg) + (CW + 1)'(1) >= (CW + 1)'(count_reg));
    end

    assign pos      = SLOT_W'(pos_reg);
    assign read_val = rv_reg;
    assign cnt      = SLOT_W'(count_reg);

endmodule

// File: hw/rtl/ste_ctrl.sv
// ste_ctrl: request sequencer for search, shift-insert, shift-delete and
// single-entry access; depends on ste_pkg
module ste_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [ste_pkg::FUNC_W-1:0]    func,
    input  logic [ste_pkg::MODE_W-1:0]    mode,
    input  ste_pkg::ste_sts_t             sts,
    output ste_pkg::ste_cmd_t             cmd,
    output logic                          set_pos_lo,
    output logic                          set_pos_mid,
    output logic                          set_pos_lo1,
    output logic                          set_pos_slot,
    output logic                          set_pos_cnt,
    output logic                          busy,
    output logic                          done,
    output logic [ste_pkg::STATUS_W-1:0]  status_q
);
    import ste_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_SRCH, S_SRCH_WAIT, S_FINAL, S_FINAL_WAIT,
        S_ADD_DEC, S_SH_UP_RD, S_SH_UP_WR, S_PUT, S_SH_DN_RD, S_SH_DN_WR,
        S_RD_WAIT, S_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic [FUNC_W-1:0]   func_reg;
    logic [MODE_W-1:0]   mode_reg;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                sorted;

    assign sorted = (mode_reg == MD_SORTED) || (mode_reg == MD_UNIQUE);

    always_comb
    begin
        state_next   = state_reg;
        status_next  = status_reg;
        cmd          = '0;
        cmd.rd       = RD_NONE;
        cmd.wr       = WR_NONE;
        set_pos_lo   = 1'b0;
        set_pos_mid  = 1'b0;
        set_pos_lo1  = 1'b0;
        set_pos_slot = 1'b0;
        set_pos_cnt  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load    = 1'b1;
                    status_next = ST_OK;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                set_pos_slot = 1'b0;
                state_next   = S_DONE;
                unique case (func_reg)
                    FN_ADD:
                    begin
                        if (sorted && !sts.empty)
                        begin
                            cmd.srch_init = 1'b1;
                            state_next    = S_SRCH;
                        end
                        else if (sts.full)
                        begin
                            status_next = ST_FULL;
                        end
                        else if (sorted)
                        begin
                            // empty table: insert at 0
                            cmd.srch_init = 1'b1;
                            state_next    = S_ADD_DEC;
                        end
                        else
                        begin
                            set_pos_cnt      = 1'b1;
                            cmd.cur_from_cnt = 1'b1;
                            state_next       = S_PUT;
                        end
                    end
                    FN_INSERT:
                    begin
                        if (sts.slot_gt_cnt)      status_next = ST_BADIDX;
                        else if (sts.full)        status_next = ST_FULL;
                        else
                        begin
                            set_pos_slot     = 1'b1;
                            cmd.cur_from_cnt = 1'b1;
                            state_next       = S_SH_UP_RD;
                        end
                    end
                    FN_DELETE:
                    begin
                        if (sts.slot_ge_cnt) status_next = ST_BADIDX;
                        else
                        begin
                            set_pos_slot      = 1'b1;
                            cmd.cur_from_slot = 1'b1;
                            state_next        = S_SH_DN_RD;
                        end
                    end
                    FN_UPDATE:
                    begin
                        if (sts.slot_ge_cnt) status_next = ST_BADIDX;
                        else
                        begin
                            set_pos_slot      = 1'b1;
                            cmd.cur_from_slot = 1'b1;
                            state_next        = S_PUT;
                        end
                    end
                    FN_SEARCH:
                    begin
                        if (sts.empty) status_next = ST_ABSENT;
                        else
                        begin
                            cmd.srch_init = 1'b1;
                            state_next    = S_SRCH;
                        end
                    end
                    FN_READ:
                    begin
                        if (sts.slot_ge_cnt) status_next = ST_BADIDX;
                        else
                        begin
                            set_pos_slot = 1'b1;
                            cmd.rd       = RD_SLOT;
                            state_next   = S_RD_WAIT;
                        end
                    end
                    default: ;
                endcase
            end
            S_SRCH:
            begin
                if (sts.srch_done)
                begin
                    if (sts.hit) state_next = S_ADD_DEC;
                    else
                    begin
                        cmd.rd     = RD_LO;
                        state_next = S_FINAL_WAIT;
                    end
                end
                else
                begin
                    cmd.rd     = RD_MID;
                    state_next = S_SRCH_WAIT;
                end
            end
            S_SRCH_WAIT:
            begin
                cmd.srch_step = 1'b1;
                state_next    = S_SRCH;
            end
            S_FINAL_WAIT:
            begin
                cmd.srch_final = 1'b1;
                state_next     = S_ADD_DEC;
            end
            S_ADD_DEC:
            begin
                // lo holds the search result here
                set_pos_lo = 1'b1;
                state_next = S_DONE;
                if (func_reg == FN_SEARCH)
                begin
                    status_next = sts.hit ? ST_FOUND : ST_ABSENT;
                end
                else if (mode_reg == MD_UNIQUE && sts.hit)
                begin
                    status_next = ST_ABSENT;
                end
                else if (sts.full)
                begin
                    set_pos_lo  = 1'b0;
                    status_next = ST_FULL;
                end
                else
                begin
                    cmd.cur_from_cnt = 1'b1;
                    state_next       = S_SH_UP_RD;
                end
            end
            S_SH_UP_RD:
            begin
                if (sts.cur_gt_pos)
                begin
                    cmd.rd     = RD_SHUP;
                    state_next = S_SH_UP_WR;
                end
                else
                begin
                    state_next = S_PUT;
                end
            end
            S_SH_UP_WR:
            begin
                cmd.wr     = WR_SHUP;
                state_next = S_SH_UP_RD;
            end
            S_PUT:
            begin
                cmd.wr      = WR_KEY;
                cmd.cnt_inc = (func_reg != FN_UPDATE);
                state_next  = S_DONE;
            end
            S_SH_DN_RD:
            begin
                if (sts.cur_last)
                begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.rd     = RD_SHDN;
                    state_next = S_SH_DN_WR;
                end
            end
            S_SH_DN_WR:
            begin
                cmd.wr     = WR_SHDN;
                state_next = S_SH_DN_RD;
            end
            S_RD_WAIT:
            begin
                cmd.take_rv = 1'b1;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            status_reg <= ST_OK;
            func_reg   <= FN_ADD;
            mode_reg   <= MD_SORTED;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
            if (cmd.load)
            begin
                func_reg <= func;
                mode_reg <= mode;
            end
        end
    end

    assign busy     = (state_reg != S_IDLE);
    assign done     = (state_reg == S_DONE);
    assign status_q = status_reg;

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy) else $error("done outside busy");
    a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done held two cycles");
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == S_DECODE) else $error("load did not decode");

endmodule

// File: hw/rtl/sorted_table_engine_unit.sv
// sorted_table_engine_unit: top level, ties controller and datapath;
// depends on ste_pkg, ste_ctrl, ste_datapath
//
//  channel  | handshake        | payload
//  request  | start / busy     | func, key, slot
//  result   | done (1 cycle)   | status, position, read_value, fill_count
//  config   | cfg_we           | cfg_data (order_mode)
//
// a search narrows its bounds by halving steps; shifting add, insert and delete
// move each entry through the single ram port. reset clears the fill count
// and sets sorted mode; the ram needs no clear. done pulses for one cycle and
// the result must be taken then.
module sorted_table_engine_unit #(
    parameter int unsigned CAPACITY  = ste_pkg::CAPACITY_DEF,
    parameter int unsigned KEY_WIDTH = ste_pkg::KEY_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [ste_pkg::MODE_W-1:0]    cfg_data,
    input  logic                          start,
    output logic                          busy,
    input  logic [ste_pkg::FUNC_W-1:0]    func,
    input  logic [KEY_WIDTH-1:0]          key,
    input  logic [ste_pkg::SLOT_W-1:0]    slot,
    output logic                          done,
    output logic [ste_pkg::STATUS_W-1:0]  status,
    output logic [ste_pkg::SLOT_W-1:0]    position,
    output logic [ste_pkg::READ_W-1:0]    read_value,
    output logic [ste_pkg::SLOT_W-1:0]    fill_count
);
    import ste_pkg::*;

    ste_cmd_t          cmd;
    ste_sts_t          sts;
    logic [MODE_W-1:0] mode_reg;
    logic              p_lo, p_mid, p_lo1, p_slot, p_cnt;
    logic [SLOT_W-1:0] pos;
    logic [READ_W-1:0] rv;
    logic [SLOT_W-1:0] cnt;
    logic [STATUS_W-1:0] st;
    logic pos_clear;
    logic [FUNC_W-1:0] func_q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MD_SORTED;
        end
        else if (cfg_we)
        begin
            mode_reg <= cfg_data;
        end
    end

    ste_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .func(func), .mode(mode_reg),
        .sts(sts), .cmd(cmd), .set_pos_lo(p_lo), .set_pos_mid(p_mid),
        .set_pos_lo1(p_lo1), .set_pos_slot(p_slot), .set_pos_cnt(p_cnt),
        .busy(busy), .done(done), .status_q(st)
    );

    ste_datapath #(.CAPACITY(CAPACITY), .KEY_WIDTH(KEY_WIDTH)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .key(key), .slot(slot),
        .set_pos_lo(p_lo), .set_pos_mid(p_mid), .set_pos_lo1(p_lo1),
        .set_pos_slot(p_slot), .set_pos_cnt(p_cnt), .pos(pos), .read_val(rv),
        .cnt(cnt)
    );

    // bad index, full, unused function codes and a search of an empty table report position 0
    assign status     = st;
    assign position   = (st == ST_BADIDX || st == ST_FULL || pos_clear) ? '0 : pos;
    assign read_value = rv;
    assign fill_count = cnt;

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            func_q <= func;
        end
    end
    assign pos_clear = !(func_q == FN_ADD || func_q == FN_INSERT || func_q == FN_DELETE
                         || func_q == FN_UPDATE || func_q == FN_SEARCH || func_q == FN_READ)
                       || (func_q == FN_SEARCH && cnt == '0);

endmodule
